// ===== src/smve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smve_pkg
// Shared types and constants of the sample mean and variance engine.
// ----------------------------------------------------------------------------
package smve_pkg;

    localparam int DATA_W          = 32;
    localparam int CNT_OUT_W       = 11;
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int DIV_W           = 64;

    localparam logic [1:0] MODE_SCALE = 2'd0;
    localparam logic [1:0] MODE_AVG   = 2'd1;
    localparam logic [1:0] MODE_MAG   = 2'd2;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_INVDEN = 1'b1;

    localparam logic [DATA_W-1:0] INVDEN_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
        logic signed [DATA_W-1:0] value_c;
        logic                     final_sample;
    } t_item;

endpackage

// ===== src/smve_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smve_queue
// Front end: takes input beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module smve_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  smve_pkg::t_item i_item,
    output logic            o_valid,
    output smve_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int FILL_W = $clog2(smve_pkg::QUEUE_DEPTH + 1);

    smve_pkg::t_item                  r_slot [smve_pkg::QUEUE_DEPTH];
    logic [smve_pkg::QUEUE_AW-1:0]    r_wp;
    logic [smve_pkg::QUEUE_AW-1:0]    r_rp;
    logic [FILL_W-1:0]                r_fill;
    logic                             push;
    logic                             pop;

    assign o_in_stall = (r_fill == FILL_W'(smve_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_fill != '0);
    assign o_item     = r_slot[r_rp];
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + FILL_W'(push) - FILL_W'(pop);
        end
    end

endmodule

// ===== src/smve_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smve_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smve_div #(
    parameter int DV_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smve_pkg::DIV_W-1:0]  i_dividend,
    input  logic [DV_W-1:0]             i_divisor,
    output logic                        o_done,
    output logic [smve_pkg::DIV_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(smve_pkg::DIV_W);

    logic [smve_pkg::DIV_W-1:0] r_quo;
    logic [DV_W-1:0]            r_rem;
    logic [DV_W-1:0]            r_dvs;
    logic [STEP_W-1:0]          r_step;
    logic                       r_busy;
    logic                       r_done;
    logic [DV_W:0]              trial;
    logic                       fits;

    assign trial      = {r_rem, r_quo[smve_pkg::DIV_W-1]};
    assign fits       = (trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[smve_pkg::DIV_W-2:0], fits};
            r_rem <= fits ? DV_W'(trial - {1'b0, r_dvs}) : trial[DV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(smve_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/smve_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smve_core
// Back end: combines samples, stores them, and computes mean and variance.
// ----------------------------------------------------------------------------
module smve_core #(
    parameter int MAX_SAMPLES = smve_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_idx,
    input  logic [smve_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                 i_q_valid,
    input  smve_pkg::t_item                      i_q_item,
    output logic                                 o_q_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [smve_pkg::DATA_W-1:0]   o_mean,
    output logic [smve_pkg::DATA_W-1:0]          o_spread,
    output logic signed [smve_pkg::DATA_W-1:0]   o_last_sample,
    output logic [smve_pkg::CNT_OUT_W-1:0]       o_sample_count,
    output logic                                 o_saturated
);

    localparam int DW    = smve_pkg::DATA_W;
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = DW + CW;
    localparam int QW    = smve_pkg::DIV_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL0   = 4'd1;
    localparam logic [3:0] ST_RND0   = 4'd2;
    localparam logic [3:0] ST_SQ     = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_RCLAMP = 4'd5;
    localparam logic [3:0] ST_STORE  = 4'd6;
    localparam logic [3:0] ST_FIN    = 4'd7;
    localparam logic [3:0] ST_DIV1   = 4'd8;
    localparam logic [3:0] ST_RD     = 4'd9;
    localparam logic [3:0] ST_DEV    = 4'd10;
    localparam logic [3:0] ST_MULD   = 4'd11;
    localparam logic [3:0] ST_ACC    = 4'd12;
    localparam logic [3:0] ST_DIV2   = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;

    logic [3:0]                r_state;
    logic [1:0]                r_mode;
    logic [DW-1:0]             r_invden;
    logic signed [DW-1:0]      r_a;
    logic signed [DW-1:0]      r_b;
    logic signed [DW-1:0]      r_c;
    logic                      r_fin;
    logic [2*DW-1:0]           r_prod;
    logic [2*DW-1:0]           r_sqsum;
    logic [5:0]                r_step;
    logic [2*DW-1:0]           r_x;
    logic [2*DW-1:0]           r_res;
    logic [2*DW-1:0]           r_bit;
    logic signed [DW-1:0]      r_smp;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CW-1:0]             r_cnt;
    logic signed [DW-1:0]      r_newest;
    logic                      r_ovf;
    logic signed [DW-1:0]      r_mean;
    logic [CW-1:0]             r_idx;
    logic [DW-1:0]             r_dmag;
    logic [2*DW-1:0]           r_sq;
    logic [2*DW-1:0]           r_acc;
    logic                      r_accsat;
    logic [DW-1:0]             r_spread;
    logic signed [DW-1:0]      r_rdata;
    logic signed [DW-1:0]      r_mem [MAX_SAMPLES];
    logic                      r_out_valid;

    logic                      emit_ok;
    logic signed [DW:0]        avg_sum;
    logic [DW-1:0]             mag_a;
    logic [DW-1:0]             sel_mag;
    logic signed [DW-1:0]      sel_val;
    logic [2*DW-1:0]           root_try;
    logic [DW+16:0]            rnd0;
    logic [CW-1:0]             m_div;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [DW:0]        dev;
    logic [2*DW:0]             acc_add;
    logic                      last_dev;
    logic                      div_start;
    logic [QW-1:0]             div_dividend;
    logic                      div_done;
    logic [QW-1:0]             div_q;
    logic [QW-16:0]            spread_rnd;

    assign emit_ok  = !r_out_valid || !i_out_stall;
    assign avg_sum  = {i_q_item.value_a[DW-1], i_q_item.value_a}
                    + {i_q_item.value_b[DW-1], i_q_item.value_b};
    assign mag_a    = r_a[DW-1] ? DW'(-r_a) : DW'(r_a);
    assign root_try = r_res + r_bit;
    assign rnd0     = DW'(0) + (DW+17)'((r_prod + 64'h8000) >> 16);
    assign m_div    = r_cnt - 1'b1;
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign dev      = {r_rdata[DW-1], r_rdata} - {r_mean[DW-1], r_mean};
    assign acc_add  = {1'b0, r_acc} + {1'b0, r_sq};
    assign last_dev = (r_idx + 1'b1) >= r_cnt;
    assign div_start = ((r_state == ST_FIN) && (r_cnt > CW'(1)))
                    || ((r_state == ST_ACC) && last_dev);
    assign div_dividend = (r_state == ST_FIN)
                        ? QW'(sum_mag) + QW'(m_div >> 1)
                        : (acc_add[2*DW] ? {QW{1'b1}} : acc_add[QW-1:0]);
    assign spread_rnd = (QW-15)'(div_q >> 16) + (QW-15)'(div_q[15]);
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;

    // component picked for the magnitude mode
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    sel_val = r_a;
            2'd1:    sel_val = r_b;
            default: sel_val = r_c;
        endcase
        sel_mag = sel_val[DW-1] ? DW'(-sel_val) : DW'(sel_val);
    end

    smve_div #(
        .DV_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (m_div),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE && r_cnt < CW'(MAX_SAMPLES)) begin
            r_mem[r_cnt[AW-1:0]] <= r_smp;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= smve_pkg::MODE_SCALE;
            r_invden    <= smve_pkg::INVDEN_RESET;
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_newest    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    smve_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    smve_pkg::CFG_INVDEN: r_invden <= i_cfg_data;
                endcase
            end
            if ((r_state == ST_EMIT) && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_a   <= i_q_item.value_a;
                        r_b   <= i_q_item.value_b;
                        r_c   <= i_q_item.value_c;
                        r_fin <= i_q_item.final_sample;
                        if (r_cnt >= CW'(MAX_SAMPLES)) begin
                            r_state <= i_q_item.final_sample ? ST_FIN : ST_IDLE;
                        end else begin
                            unique case (r_mode)
                                smve_pkg::MODE_AVG: begin
                                    r_smp   <= avg_sum[DW:1];
                                    r_state <= ST_STORE;
                                end
                                smve_pkg::MODE_MAG: begin
                                    r_step  <= '0;
                                    r_sqsum <= '0;
                                    r_state <= ST_SQ;
                                end
                                default: r_state <= ST_MUL0;
                            endcase
                        end
                    end
                end
                ST_MUL0: begin
                    r_prod  <= (2*DW)'(mag_a) * (2*DW)'(r_invden);
                    r_state <= ST_RND0;
                end
                ST_RND0: begin
                    if (!r_a[DW-1]) begin
                        if (rnd0 > (DW+17)'(32'h7FFF_FFFF)) begin
                            r_smp <= 32'sh7FFF_FFFF;
                            r_ovf <= 1'b1;
                        end else begin
                            r_smp <= DW'(rnd0);
                        end
                    end else begin
                        if (rnd0 > (DW+17)'(32'h8000_0000)) begin
                            r_smp <= 32'sh8000_0000;
                            r_ovf <= 1'b1;
                        end else begin
                            r_smp <= DW'(-rnd0);
                        end
                    end
                    r_state <= ST_STORE;
                end
                ST_SQ: begin
                    // multiply one component while the previous square is added
                    r_prod  <= (2*DW)'(sel_mag) * (2*DW)'(sel_mag);
                    r_sqsum <= r_sqsum + ((r_step != '0) ? r_prod : '0);
                    if (r_step == 6'd3) begin
                        r_x     <= r_sqsum + r_prod;
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_step  <= '0;
                        r_state <= ST_ROOT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (r_x >= root_try) begin
                        r_x   <= r_x - root_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'd31) begin
                        r_state <= ST_RCLAMP;
                    end
                end
                ST_RCLAMP: begin
                    if (r_res > 64'h7FFF_FFFF) begin
                        r_smp <= 32'sh7FFF_FFFF;
                        r_ovf <= 1'b1;
                    end else begin
                        r_smp <= DW'(r_res);
                    end
                    r_state <= ST_STORE;
                end
                ST_STORE: begin
                    if (r_cnt != '0) begin
                        r_sum <= r_sum + SUM_W'(r_smp);
                    end
                    r_newest <= r_smp;
                    r_cnt    <= r_cnt + 1'b1;
                    r_state  <= r_fin ? ST_FIN : ST_IDLE;
                end
                ST_FIN: begin
                    if (r_cnt > CW'(1)) begin
                        r_state <= ST_DIV1;
                    end else begin
                        r_mean   <= '0;
                        r_spread <= '0;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_mean   <= r_sum[SUM_W-1] ? DW'(-div_q) : DW'(div_q);
                        r_idx    <= CW'(1);
                        r_acc    <= '0;
                        r_accsat <= 1'b0;
                        r_state  <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_DEV;
                end
                ST_DEV: begin
                    r_dmag  <= dev[DW] ? DW'(-dev) : DW'(dev);
                    r_state <= ST_MULD;
                end
                ST_MULD: begin
                    r_sq    <= (2*DW)'(r_dmag) * (2*DW)'(r_dmag);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (acc_add[2*DW]) begin
                        r_acc    <= '1;
                        r_accsat <= 1'b1;
                    end else begin
                        r_acc <= acc_add[2*DW-1:0];
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= last_dev ? ST_DIV2 : ST_RD;
                end
                ST_DIV2: begin
                    if (div_done) begin
                        if (r_accsat || spread_rnd > (QW-15)'(32'hFFFF_FFFF)) begin
                            r_spread <= '1;
                            r_ovf    <= 1'b1;
                        end else begin
                            r_spread <= DW'(spread_rnd);
                        end
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_ok) begin
                        o_mean         <= r_mean;
                        o_spread       <= r_spread;
                        o_last_sample  <= r_newest;
                        o_sample_count <= smve_pkg::CNT_OUT_W'(r_cnt);
                        o_saturated    <= r_ovf;
                        r_sum          <= '0;
                        r_cnt          <= '0;
                        r_ovf          <= 1'b0;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/sample_mean_variance_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_mean_variance_engine_unit
// Stores a series of combined samples and reports mean and variance at its end.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   value_a, value_b, value_c, final_sample
//  out       output     o_out_valid / i_out_stall mean, spread, last_sample, sample_count,
//                                                 saturated
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  in the back end a sample in mode 0 passes the multiplier and the rounding clamp, in mode 1
//  goes straight to the store, and in mode 2 passes the squares and the one-step-per-cycle
//  square root; a final beat adds two divides, for the mean and then the variance, around a store re-read
//  two beats fit in the front queue while the back end works; a stalled result waits
//  in the output register. synchronous active-low reset clears the series state
// ----------------------------------------------------------------------------
module sample_mean_variance_engine_unit #(
    parameter int MAX_SAMPLES = smve_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [smve_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [smve_pkg::DATA_W-1:0] i_value_a,
    input  logic signed [smve_pkg::DATA_W-1:0] i_value_b,
    input  logic signed [smve_pkg::DATA_W-1:0] i_value_c,
    input  logic                               i_final_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [smve_pkg::DATA_W-1:0] o_mean,
    output logic [smve_pkg::DATA_W-1:0]        o_spread,
    output logic signed [smve_pkg::DATA_W-1:0] o_last_sample,
    output logic [smve_pkg::CNT_OUT_W-1:0]     o_sample_count,
    output logic                               o_saturated
);

    smve_pkg::t_item in_item;
    smve_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    assign in_item.value_a      = i_value_a;
    assign in_item.value_b      = i_value_b;
    assign in_item.value_c      = i_value_c;
    assign in_item.final_sample = i_final_sample;

    smve_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .o_valid    (q_valid),
        .o_item     (q_item),
        .i_pop      (q_pop)
    );

    smve_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mean         (o_mean),
        .o_spread       (o_spread),
        .o_last_sample  (o_last_sample),
        .o_sample_count (o_sample_count),
        .o_saturated    (o_saturated)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample mean and variance engine: drives series
// of samples under every combine mode, predicts mean, variance, last sample,
// count and saturation per series, and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int  STORE_DEPTH = smve_pkg::MAX_SAMPLES_DEF;
    localparam int  IDLE_PCT    = 12;
    localparam int  TAIL_CYCLES = 300;
    localparam longint LIMIT    = 1000000;

    typedef struct {
        logic signed [31:0] mean;
        logic [31:0]        spread;
        logic signed [31:0] last_sample;
        logic [10:0]        sample_count;
        logic               saturated;
    } t_series_stats;

    class series_stats_board;
        int                 store [STORE_DEPTH];
        longint             run_sum;
        int                 count;
        int                 newest;
        bit                 clipped;
        logic [1:0]         mode;
        logic [31:0]        inv_den;
        t_series_stats      expected_q [$];
        int                 errors;

        function void clear();
            run_sum = 0; count = 0; newest = 0; clipped = 0;
            mode = smve_pkg::MODE_SCALE; inv_den = smve_pkg::INVDEN_RESET; errors = 0;
        endfunction

        function bit [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function int clip32(bit neg, bit [63:0] m);
            if (!neg) begin
                if (m > 64'h7FFF_FFFF) begin
                    clipped = 1;
                    return 32'h7FFF_FFFF;
                end
                return int'(m);
            end
            if (m > 64'h8000_0000) begin
                clipped = 1;
                return 32'h8000_0000;
            end
            return int'(-longint'(m));
        endfunction

        function bit [63:0] root64(bit [63:0] x);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function int combine(longint a, longint b, longint c);
            bit [63:0] p;
            longint s;
            case (mode)
                smve_pkg::MODE_AVG: begin
                    s = a + b;
                    return int'(s >>> 1);
                end
                smve_pkg::MODE_MAG: begin
                    p = mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
                    return clip32(0, root64(p));
                end
                default: begin
                    p = mag(a) * 64'(inv_den);
                    return clip32(a < 0, (p + 64'h8000) >> 16);
                end
            endcase
        endfunction

        function void note_sample(logic signed [31:0] a, logic signed [31:0] b,
                                  logic signed [31:0] c, logic fin);
            t_series_stats e;
            int s;
            longint avg;
            bit [63:0] m, q, acc, d, sq, sp;
            bit acc_sat;
            if (count < STORE_DEPTH) begin
                s = combine(a, b, c);
                store[count] = s;
                if (count > 0) run_sum += s;
                newest = s;
                count++;
            end
            if (!fin) return;
            avg = 0;
            sp = 0;
            if (count > 1) begin
                m = 64'(count - 1);
                q = (mag(run_sum) + m / 2) / m;
                avg = run_sum < 0 ? -longint'(q) : longint'(q);
                acc = 0;
                acc_sat = 0;
                for (int i = 1; i < count; i++) begin
                    d = mag(longint'(store[i]) - avg);
                    sq = d * d;
                    if (acc > ~64'd0 - sq) begin
                        acc = ~64'd0;
                        acc_sat = 1;
                    end else begin
                        acc += sq;
                    end
                end
                q = acc / m;
                sp = (q >> 16) + ((q >> 15) & 64'd1);
                if (acc_sat || sp > 64'hFFFF_FFFF) begin
                    sp = 64'hFFFF_FFFF;
                    clipped = 1;
                end
            end
            e.mean = avg[31:0];
            e.spread = sp[31:0];
            e.last_sample = newest;
            e.sample_count = 11'(count);
            e.saturated = clipped;
            expected_q.push_back(e);
            run_sum = 0;
            count = 0;
            clipped = 0;
        endfunction

        function void check_result(t_series_stats got);
            t_series_stats e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat mean=%h", $time, got.mean);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.mean !== e.mean) begin
                $display("%0t: mean exp %h got %h", $time, e.mean, got.mean);
                errors++;
            end
            if (got.spread !== e.spread) begin
                $display("%0t: spread exp %h got %h", $time, e.spread, got.spread);
                errors++;
            end
            if (got.last_sample !== e.last_sample) begin
                $display("%0t: last_sample exp %h got %h", $time, e.last_sample,
                         got.last_sample);
                errors++;
            end
            if (got.sample_count !== e.sample_count) begin
                $display("%0t: sample_count exp %0d got %0d", $time, e.sample_count,
                         got.sample_count);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $display("%0t: saturated exp %b got %b", $time, e.saturated,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_value_a;
    logic signed [31:0] i_value_b;
    logic signed [31:0] i_value_c;
    logic               i_final_sample;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_mean;
    logic [31:0]        o_spread;
    logic signed [31:0] o_last_sample;
    logic [10:0]        o_sample_count;
    logic               o_saturated;

    sample_mean_variance_engine_unit u_top (.*);

    series_stats_board board;
    longint cycles;
    int     items_sent;
    int     results_seen;
    bit     quiet;

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = smve_pkg::CFG_MODE;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_value_a = 0;
        i_value_b = 0;
        i_value_c = 0;
        i_final_sample = 0;
        i_out_stall = 0;
        cycles = 0;
        items_sent = 0;
        results_seen = 0;
        quiet = 0;
        board = new();
        board.clear();
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_series_stats got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.mean = o_mean;
            got.spread = o_spread;
            got.last_sample = o_last_sample;
            got.sample_count = o_sample_count;
            got.saturated = o_saturated;
            board.check_result(got);
            results_seen++;
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 20) begin
                held = 1;
                hold = 800;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall = 1;
            end else begin
                i_out_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic cfg_write(logic idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        if (idx == smve_pkg::CFG_MODE) board.mode = data[1:0];
        else board.inv_den = data;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // valid stays high from one beat to the next unless a gap is rolled
    task automatic send_sample(logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] c, logic fin);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_value_a = a;
        i_value_b = b;
        i_value_c = c;
        i_final_sample = fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_sample(a, b, c, fin);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 0;
        @(negedge i_clk);
        while (board.expected_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h3FFFF) - 32'h20000;
            2: return $urandom_range(32'h1FFFFFF) - 32'h1000000;
            3: case ($urandom_range(3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return $urandom_range(32'h7FFFFF) - 32'h400000;
        endcase
    endfunction

    function automatic logic [31:0] pick_inv_den();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return smve_pkg::INVDEN_RESET;
            3: return $urandom_range(32'h3FFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_series(int len);
        for (int i = 0; i < len; i++)
            send_sample(pick_value(), pick_value(), pick_value(), i == len - 1);
    endtask

    initial begin
        int series_n;
        int len;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset config, single-sample series, extremes
        send_sample(32'h0001_8000, 0, 0, 1);
        send_sample(32'h7FFF_FFFF, 0, 0, 0);
        send_sample(32'h7FFF_FFFF, 0, 0, 0);
        send_sample(32'h8000_0000, 0, 0, 0);
        send_sample(32'hFFFF_FFFF, 0, 0, 1);
        drain();
        cfg_write(smve_pkg::CFG_INVDEN, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 0, 0, 0);
        send_sample(32'h8000_0000, 0, 0, 0);
        send_sample(32'h0000_0001, 0, 0, 0);
        send_sample(32'hFFFF_FFFF, 0, 0, 1);
        drain();
        cfg_write(smve_pkg::CFG_INVDEN, 32'h0);
        cfg_write(smve_pkg::CFG_MODE, 2'd3);      // unused code behaves as scaling
        send_sample(32'h7FFF_FFFF, 0, 0, 0);
        send_sample(32'h1234_5678, 0, 0, 1);
        drain();
        cfg_write(smve_pkg::CFG_MODE, smve_pkg::MODE_AVG);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_sample(32'h8000_0000, 32'h8000_0000, 0, 0);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000, 0, 1);  // variance clips
        drain();
        cfg_write(smve_pkg::CFG_MODE, smve_pkg::MODE_MAG);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_sample(32'h0003_0000, 32'h0004_0000, 32'h0, 0);
        send_sample(32'h7FFF_FFFF, 32'h0, 32'h0, 0);
        send_sample(32'h0, 32'h0, 32'hFFFF_0000, 1);
        drain();

        // random phases, each with its own register setting
        while (items_sent < 950) begin
            cfg_write(smve_pkg::CFG_MODE, $urandom_range(3));
            cfg_write(smve_pkg::CFG_INVDEN, pick_inv_den());
            quiet = (items_sent > 350 && items_sent < 550);
            series_n = $urandom_range(1, 8);
            for (int s = 0; s < series_n; s++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 60)
                                               : $urandom_range(1, 10);
                send_series(len);
            end
            drain();
        end

        board.errors += board.expected_q.size();
        if (board.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/smve_pkg.sv
src/smve_queue.sv
src/smve_div.sv
src/smve_core.sv
src/sample_mean_variance_engine_unit.sv
tb/tb.sv
